// ----- hdl/utf8_sequence_decoder_defines.svh -----
// ============================================================================
// utf8_sequence_decoder assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ============================================================================
`ifndef UTF8_SEQUENCE_DECODER_DEFINES_SVH
`define UTF8_SEQUENCE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- hdl/u8d_pkg.sv -----
// ============================================================================
// u8d_pkg
// Types, constants and decode helpers of the UTF-8 sequence decoder.
// ============================================================================
`default_nettype none

package u8d_pkg;

    localparam int WIN_BYTES = 6;            // bytes in the input window
    localparam int WIN_CONT  = WIN_BYTES - 1; // continuation slots
    localparam int CONT_BITS = 6;
    localparam int CP_W      = 31;
    localparam int LEN_W     = 3;
    localparam int ONES_W    = 4;            // leading-ones count, 0..8

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_LEAD = 3'd2,
        ST_SHORT    = 3'd3,
        ST_BAD_CONT = 3'd4
    } t_status;

    // per-lane finding on one continuation byte
    typedef struct packed {
        logic                 ok;
        logic [CONT_BITS-1:0] bits;
    } t_lane_res;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0]  cp;
        t_status          status;
    } t_result;

    // run of ones from the MSB down
    function automatic logic [ONES_W-1:0] lead_ones(input logic [7:0] b);
        logic [ONES_W-1:0] n;
        n = ONES_W'(8);
        for (int k = 7; k >= 0; k--) begin
            if (!b[k] && n == ONES_W'(8)) begin
                n = ONES_W'(7 - k);
            end
        end
        return n;
    endfunction

    // payload bits of the lead byte: low (7 - ones) bits
    function automatic logic [6:0] lead_mask(input logic [ONES_W-1:0] ones);
        logic [6:0] m;
        unique case (ones)
            4'd0:    m = 7'h7F;
            4'd1:    m = 7'h3F;
            4'd2:    m = 7'h1F;
            4'd3:    m = 7'h0F;
            4'd4:    m = 7'h07;
            4'd5:    m = 7'h03;
            4'd6:    m = 7'h01;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/u8d_if.sv -----
// ============================================================================
// u8d channel interfaces
// Valid/ready channels for byte windows in and decode results out.
// ============================================================================
`default_nettype none

interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] lead_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [7:0] fifth_byte;
    logic [7:0] sixth_byte;
    logic [2:0] available_count;

    modport source (
        output valid, lead_byte, second_byte, third_byte, fourth_byte,
               fifth_byte, sixth_byte, available_count,
        input  ready
    );
    modport sink (
        input  valid, lead_byte, second_byte, third_byte, fourth_byte,
               fifth_byte, sixth_byte, available_count,
        output ready
    );
endinterface

interface u8d_out_if
    import u8d_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [LEN_W-1:0] consumed_length;
    logic [CP_W-1:0] code_point;
    t_status         status;

    modport source (
        output valid, consumed_length, code_point, status,
        input  ready
    );
    modport sink (
        input  valid, consumed_length, code_point, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/u8d_lane.sv -----
// ============================================================================
// u8d_lane
// Checks one window byte for the 10xxxxxx tag and extracts its payload.
// ============================================================================
`default_nettype none

module u8d_lane
    import u8d_pkg::*;
(
    input  wire logic [7:0] i_byte,
    output t_lane_res       o_res
);

    assign o_res.ok   = (i_byte[7:6] == CONT_TAG);
    assign o_res.bits = i_byte[CONT_BITS-1:0];

endmodule

`default_nettype wire

// ----- hdl/u8d_merge.sv -----
// ============================================================================
// u8d_merge
// Decodes the lead byte and merges lane findings into length, code point
// and status.
// ============================================================================
`default_nettype none

module u8d_merge
    import u8d_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = 6,
    parameter int LANES         = MAX_SEQ_BYTES - 1
) (
    input  wire logic [7:0]  i_lead,
    input  wire logic [2:0]  i_avail,
    input  wire t_lane_res [LANES-1:0] i_lanes,
    output t_result          o_result
);

    logic [ONES_W-1:0] ones;
    logic [LEN_W-1:0]  avail_c;
    logic [LEN_W-1:0]  need;
    logic              bad_lead;
    logic              bad_cont;
    logic [CP_W-1:0]   cp;

    always_comb begin
        ones     = lead_ones(i_lead);
        avail_c  = (i_avail > LEN_W'(WIN_BYTES)) ? LEN_W'(WIN_BYTES) : i_avail;
        need     = (ones == '0) ? LEN_W'(1) : ones[LEN_W-1:0];
        bad_lead = (ones == ONES_W'(1)) || (ones > ONES_W'(MAX_SEQ_BYTES));

        // lanes past the sequence length are ignored
        bad_cont = 1'b0;
        cp       = CP_W'(i_lead[6:0] & lead_mask(ones));
        for (int i = 0; i < LANES; i++) begin
            if (LEN_W'(i + 1) < need) begin
                if (!i_lanes[i].ok) begin
                    bad_cont = 1'b1;
                end
                cp = {cp[CP_W-CONT_BITS-1:0], i_lanes[i].bits};
            end
        end

        o_result.len = '0;
        o_result.cp  = '0;
        priority if (i_avail == '0) begin
            o_result.status = ST_EMPTY;
        end else if (bad_lead) begin
            o_result.status = ST_BAD_LEAD;
        end else if (avail_c < need) begin
            o_result.status = ST_SHORT;
        end else if (bad_cont) begin
            o_result.status = ST_BAD_CONT;
        end else begin
            o_result.status = ST_OK;
            o_result.len    = need;
            o_result.cp     = cp;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/utf8_sequence_decoder.sv -----
// An accepted window is registered in the output register or skid entry.
// Throughput: one window per cycle while the skid entry is free; the
// continuation bytes are checked by parallel lanes and merged in the same
// cycle ahead of the output register. The two-entry output stage keeps
// input ready for one extra transaction while a result is stalled. Reset
// is synchronous, active low, empties both entries; no other state exists.
// ============================================================================
// utf8_sequence_decoder
// Decodes one original-form UTF-8 sequence (1 to 6 bytes, 31-bit code
// point) from a six-byte window per transaction.
// ============================================================================
`default_nettype none
`include "utf8_sequence_decoder_defines.svh"

module utf8_sequence_decoder
    import u8d_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = 6     // longest accepted sequence, 4..6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out
);

    // one lane per continuation byte that a legal sequence can reach
    localparam int LANES = MAX_SEQ_BYTES - 1;

    logic [7:0]             cont_bytes [WIN_CONT];
    t_lane_res [LANES-1:0]  lane_res;
    t_result                dec;

    // output register and skid entry
    logic    r_out_v;
    logic    n_out_v;
    t_result r_out;
    t_result n_out;
    logic    r_skid_v;
    logic    n_skid_v;
    t_result r_skid;
    t_result n_skid;

    logic in_acc;
    logic out_take;

    assign cont_bytes[0] = i_in.second_byte;
    assign cont_bytes[1] = i_in.third_byte;
    assign cont_bytes[2] = i_in.fourth_byte;
    assign cont_bytes[3] = i_in.fifth_byte;
    assign cont_bytes[4] = i_in.sixth_byte;

    // ------------------------------------------------------------------
    // Continuation lanes: tag check and payload extraction, side by side
    // ------------------------------------------------------------------
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        u8d_lane u_lane (
            .i_byte (cont_bytes[g]),
            .o_res  (lane_res[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge: lead byte decode, error priority, code point assembly
    // ------------------------------------------------------------------
    u8d_merge #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES),
        .LANES         (LANES)
    ) u_merge (
        .i_lead   (i_in.lead_byte),
        .i_avail  (i_in.available_count),
        .i_lanes  (lane_res),
        .o_result (dec)
    );

    // ------------------------------------------------------------------
    // Output stage. Input is ready whenever the skid entry is free, so a
    // new transaction is taken even while the output register is stalled.
    // ------------------------------------------------------------------
    assign i_in.ready = !r_skid_v;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_take   = r_out_v && o_out.ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (!r_out_v || out_take) begin
            if (r_skid_v) begin
                // skid drains first; input is held off while it is full
                n_out_v  = 1'b1;
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = in_acc;
                n_out   = dec;
            end
        end else if (in_acc) begin
            n_skid_v = 1'b1;
            n_skid   = dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid           = r_out_v;
    assign o_out.consumed_length = r_out.len;
    assign o_out.code_point      = r_out.cp;
    assign o_out.status          = r_out.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_v && !r_out_v)
    `ASSERT_CLK(a_stalled_accept_to_skid, i_clk, i_rst_n,
        (in_acc && r_out_v && !o_out.ready) |=> r_skid_v)
    `ASSERT_CLK(a_ok_length_range, i_clk, i_rst_n,
        (r_out_v && r_out.status == ST_OK) |->
            (r_out.len != '0 && r_out.len <= LEN_W'(MAX_SEQ_BYTES)))
    `ASSERT_CLK(a_error_clears_result, i_clk, i_rst_n,
        (r_out_v && r_out.status != ST_OK) |-> (r_out.len == '0 && r_out.cp == '0))

endmodule

`default_nettype wire

// ----- tb/utf8_decode_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches both channels of the decoder, works out the expected decode of
// every accepted byte window and compares it with the returned result.
// ----------------------------------------------------------------------------
module utf8_decode_checker
    import u8d_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_end_check,
    u8d_in_if         i_in,
    u8d_out_if        i_out,
    output int        o_fail_count,
    output int        o_outstanding
);

    t_result expected_decodes[$];
    int      fail_count   = 0;
    int      result_count = 0;
    int      status_hits[5] = '{default: 0};
    bit      end_reported = 1'b0;

    // Decode of one window: empty, lead, short, then continuations in order.
    function automatic t_result decode_window(input logic [WIN_BYTES-1:0][7:0] win,
                                              input logic [2:0] count);
        t_result    res;
        int         avail;
        int         ones;
        int         need;
        logic [CP_W-1:0] cp;
        res.len    = '0;
        res.cp     = '0;
        res.status = ST_OK;
        avail = (int'(count) > WIN_BYTES) ? WIN_BYTES : int'(count);
        if (avail == 0) begin
            res.status = ST_EMPTY;
            return res;
        end
        ones = 0;
        while (ones < 8 && win[0][7 - ones]) begin
            ones++;
        end
        if (ones == 0) begin
            need = 1;
        end else if (ones >= 2 && ones <= MAX_SEQ_BYTES && ones <= WIN_BYTES) begin
            need = ones;
        end else begin
            res.status = ST_BAD_LEAD;
            return res;
        end
        if (avail < need) begin
            res.status = ST_SHORT;
            return res;
        end
        cp = CP_W'(win[0]) & ((CP_W'(1) << (7 - ones)) - CP_W'(1));
        for (int i = 1; i < need; i++) begin
            if (win[i][7:6] != CONT_TAG) begin
                res.status = ST_BAD_CONT;
                return res;
            end
            cp = (cp << CONT_BITS) | CP_W'(win[i][CONT_BITS-1:0]);
        end
        res.len = LEN_W'(need);
        res.cp  = cp;
        return res;
    endfunction

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] decode check: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            // results first: the output is registered, so nothing accepted on
            // this edge can already be on the output
            if (i_out.valid && i_out.ready) begin
                got.len    = i_out.consumed_length;
                got.cp     = i_out.code_point;
                got.status = i_out.status;
                if (expected_decodes.size() == 0) begin
                    report_failure($sformatf("result with nothing pending: len=%0d cp=%h st=%0d",
                                             got.len, got.cp, got.status));
                end else begin
                    want = expected_decodes.pop_front();
                    result_count++;
                    status_hits[want.status]++;
                    if (got.len !== want.len || got.cp !== want.cp
                            || got.status !== want.status) begin
                        report_failure($sformatf(
                            "mismatch: expected len=%0d cp=%h st=%0d, got len=%0d cp=%h st=%0d",
                            want.len, want.cp, want.status, got.len, got.cp, got.status));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_decodes.push_back(decode_window(
                    {i_in.sixth_byte, i_in.fifth_byte, i_in.fourth_byte,
                     i_in.third_byte, i_in.second_byte, i_in.lead_byte},
                    i_in.available_count));
            end
            if (i_end_check && !end_reported) begin
                end_reported = 1'b1;
                if (expected_decodes.size() != 0) begin
                    report_failure($sformatf("%0d results never arrived",
                                             expected_decodes.size()));
                end
                $display("checked %0d decodes: ok %0d, empty %0d, bad lead %0d, short %0d, bad cont %0d",
                         result_count, status_hits[ST_OK], status_hits[ST_EMPTY],
                         status_hits[ST_BAD_LEAD], status_hits[ST_SHORT],
                         status_hits[ST_BAD_CONT]);
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_decodes.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for utf8_sequence_decoder: directed windows covering
// every length and fault, then random well-formed and broken sequences under
// random idling on both channels, a long output hold-off and full-rate runs.
// ----------------------------------------------------------------------------
module tb_top;
    import u8d_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int MAX_SEQ     = 6;      // decoder built for full six-byte form
    localparam int HOLD_CYCLES = 300;    // long output stall, fills the skid stage
    localparam int CYCLE_LIMIT = 200000;

    // one input transaction: window byte k sits in win[k]
    typedef struct packed {
        logic [WIN_BYTES-1:0][7:0] win;
        logic [2:0]                count;
    } t_window;

    logic clk = 1'b0;
    logic rst_n;
    logic end_check;

    int fail_total;
    int outstanding;
    int cycle_count     = 0;
    int windows_offered = 0;
    int hold_offs       = 0;

    // idling switches, flipped between phases
    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;
    bit hold_off_req = 1'b0;

    u8d_in_if  in_ch ();
    u8d_out_if out_ch ();

    utf8_sequence_decoder #(
        .MAX_SEQ_BYTES(MAX_SEQ)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    utf8_decode_checker #(
        .MAX_SEQ_BYTES(MAX_SEQ)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_end_check  (end_check),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_total),
        .o_outstanding(outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run-away guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** utf8_sequence_decoder: FAILED **");
            $finish;
        end
    end

    function automatic int idle_draw(input bit enabled);
        return enabled ? $urandom_range(0, 11) : 0;
    endfunction

    function automatic t_window window_of(input logic [7:0] b0, b1, b2, b3, b4, b5,
                                          input logic [2:0] cnt);
        t_window w;
        w.win   = {b5, b4, b3, b2, b1, b0};
        w.count = cnt;
        return w;
    endfunction

    // Mostly well-formed sequences with random payload; the rest are short
    // windows, broken continuations, bad lead bytes and raw noise.
    function automatic t_window random_window();
        t_window    w;
        int         len;
        int         kind;
        int         pos;
        logic [7:0] b;
        w.win   = 48'({$urandom(), $urandom()});
        w.count = 3'($urandom_range(0, 7));
        kind    = $urandom_range(0, 99);
        if (kind >= 95) begin
            return w;
        end
        if (kind >= 90) begin
            // lead byte with one, seven or eight leading ones
            case ($urandom_range(0, 2))
                0:       w.win[0][7:6] = 2'b10;
                1:       w.win[0] = 8'hFE;
                default: w.win[0] = 8'hFF;
            endcase
            w.count = 3'($urandom_range(1, 7));
            return w;
        end
        len = $urandom_range(1, MAX_SEQ);
        if (len == 1) begin
            w.win[0][7] = 1'b0;
        end else begin
            w.win[0] = (8'hFF << (8 - len)) | (w.win[0] & (8'hFF >> (len + 1)));
        end
        for (int i = 1; i < len; i++) begin
            w.win[i][7:6] = CONT_TAG;
        end
        w.count = 3'($urandom_range(len, 7));
        if (kind >= 80 && len > 1) begin
            pos = $urandom_range(1, len - 1);
            do begin
                b = 8'($urandom());
            end while (b[7:6] == CONT_TAG);
            w.win[pos] = b;
        end else if (kind >= 70) begin
            // fewer bytes than the header asks for (count 0 when len is 1)
            w.count = 3'($urandom_range(0, len - 1));
        end
        return w;
    endfunction

    // Offer one window, after an optional gap, and hold it until taken.
    task automatic offer_window(input t_window w);
        int gap;
        gap = idle_draw(send_idle);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.lead_byte       <= w.win[0];
        in_ch.second_byte     <= w.win[1];
        in_ch.third_byte      <= w.win[2];
        in_ch.fourth_byte     <= w.win[3];
        in_ch.fifth_byte      <= w.win[4];
        in_ch.sixth_byte      <= w.win[5];
        in_ch.available_count <= w.count;
        in_ch.valid           <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        windows_offered++;
    endtask

    // Stop offering and wait for every pending result. The first edge lets
    // the checker register the last transaction before its count is read.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic offer_random(input int n);
        for (int i = 0; i < n; i++) begin
            offer_window(random_window());
        end
    endtask

    // Result side: random stalls per transaction, plus one long hold-off
    // on request, counted here while the sender keeps pushing.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end
            stall = idle_draw(recv_idle);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial begin
        rst_n                 <= 1'b0;
        end_check             <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.lead_byte       <= '0;
        in_ch.second_byte     <= '0;
        in_ch.third_byte      <= '0;
        in_ch.fourth_byte     <= '0;
        in_ch.fifth_byte      <= '0;
        in_ch.sixth_byte      <= '0;
        in_ch.available_count <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed windows ----
        // empty window, even with a bad lead byte present
        offer_window(window_of(8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0));
        offer_window(window_of(8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0));
        // single byte extremes; trailing window bytes are ignored
        offer_window(window_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1));
        offer_window(window_of(8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6));
        // lead bytes with one, seven and eight ones; bad lead beats short
        offer_window(window_of(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd1));
        offer_window(window_of(8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
        offer_window(window_of(8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
        offer_window(window_of(8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6));
        // lengths two to six; smallest payload of two and five bytes, largest of two to five
        offer_window(window_of(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
        offer_window(window_of(8'hDF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6));
        offer_window(window_of(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd3));
        offer_window(window_of(8'hEF, 8'hBF, 8'hBF, 8'h00, 8'h00, 8'h00, 3'd4));
        offer_window(window_of(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd4));
        offer_window(window_of(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h41, 8'h41, 3'd5));
        offer_window(window_of(8'hF8, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5));
        offer_window(window_of(8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd5));
        offer_window(window_of(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
        // largest code point, count of seven read as six
        offer_window(window_of(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7));
        // short sequences; short wins over a bad continuation
        offer_window(window_of(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd2));
        offer_window(window_of(8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd5));
        offer_window(window_of(8'hE2, 8'h41, 8'h41, 8'h00, 8'h00, 8'h00, 3'd2));
        // broken continuation, first and last position, first one reported
        offer_window(window_of(8'hFC, 8'h41, 8'hC0, 8'h80, 8'h80, 8'h80, 3'd6));
        offer_window(window_of(8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'hC0, 3'd6));
        offer_window(window_of(8'hC2, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 3'd7));
        wait_for_drain();

        // ---- random, idling on both sides ----
        offer_random(280);
        wait_for_drain();

        // ---- long output hold-off while windows keep coming ----
        send_idle    = 1'b0;
        recv_idle    = 1'b0;
        hold_off_req = 1'b1;
        offer_random(40);
        wait_for_drain();

        // ---- full rate, no idling anywhere ----
        offer_random(150);
        wait_for_drain();

        // ---- random again ----
        send_idle = 1'b1;
        recv_idle = 1'b1;
        offer_random(180);
        wait_for_drain();

        // allow for the output register and skid entry, then final check
        repeat (4) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        $display("windows offered: %0d, long output hold-offs: %0d",
                 windows_offered, hold_offs);
        if (fail_total == 0) begin
            $display("** utf8_sequence_decoder: PASSED **");
        end else begin
            $display("** utf8_sequence_decoder: FAILED **");
        end
        $finish;
    end

endmodule

// ----- utf8_sequence_decoder.f -----
+incdir+hdl
hdl/u8d_pkg.sv
hdl/u8d_if.sv
hdl/u8d_lane.sv
hdl/u8d_merge.sv
hdl/utf8_sequence_decoder.sv
tb/utf8_decode_checker.sv
tb/tb_top.sv
